@@ sv/vpi_pkg.sv @@
package vpi_pkg;

	// Q16.16 one
	localparam logic [31:0] Q_ONE = 32'h0001_0000;

	// opcodes of an input word
	localparam logic [1:0] OP_PLACE = 2'd0;
	localparam logic [1:0] OP_FORCE = 2'd1;
	localparam logic [1:0] OP_DAMP  = 2'd2;
	localparam logic [1:0] OP_INTEG = 2'd3;

	// configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MASS     = 2'd0;
	localparam cfg_idx_t CFG_MASS_INF = 2'd1;
	localparam cfg_idx_t CFG_CFORCE_X = 2'd2;
	localparam cfg_idx_t CFG_CFORCE_Y = 2'd3;

	// divider: 32 quotient bits, dividend is |num| * 2^16 (up to 50 bits)
	localparam int DIV_STEPS = 32;
	localparam int DIV_NUM_W = 50;

	typedef struct packed {
		logic                 start;
		logic                 neg;
		logic [DIV_NUM_W-1:0] num_mag;
		logic [31:0]          den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quot;
	} div_rsp_t;

	// clip to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		logic signed [31:0] r;
		if (v > 52'sh0_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -52'sh0_0000_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [51:0] sx32(input logic signed [31:0] v);
		return {{20{v[31]}}, v};
	endfunction

	function automatic logic signed [51:0] sx50(input logic signed [49:0] v);
		return {{2{v[49]}}, v};
	endfunction

endpackage

@@ sv/vpi_in_if.sv @@
interface vpi_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic signed [31:0] vector_x;
	logic signed [31:0] vector_y;
	logic [31:0]        scalar_value;

	modport source (output valid, output opcode, output vector_x, output vector_y,
		output scalar_value, input ready);
	modport sink (input valid, input opcode, input vector_x, input vector_y,
		input scalar_value, output ready);
endinterface

@@ sv/vpi_out_if.sv @@
interface vpi_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position_x_out;
	logic signed [31:0] position_y_out;
	logic signed [31:0] velocity_x_out;
	logic signed [31:0] velocity_y_out;
	logic               divide_error;

	modport source (output valid, output position_x_out, output position_y_out,
		output velocity_x_out, output velocity_y_out, output divide_error, input ready);
	modport sink (input valid, input position_x_out, input position_y_out,
		input velocity_x_out, input velocity_y_out, input divide_error, output ready);
endinterface

@@ sv/vpi_divider.sv @@
// Radix-2 restoring divider: sat(trunc(+/- num_mag / den)), one quotient bit a cycle.
module vpi_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  vpi_pkg::div_req_t req,
	output vpi_pkg::div_rsp_t rsp
);
	import vpi_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam logic [1:0] DV_IDLE = 2'd0;
	localparam logic [1:0] DV_RUN  = 2'd1;
	localparam logic [1:0] DV_DONE = 2'd2;

	logic [1:0]       dv_state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      rem_q;
	logic [31:0]      quo_q;
	logic [31:0]      den_q;
	logic             neg_q;
	logic             clamp_q;
	logic             zero_q;

	logic [32:0] r2;
	logic [32:0] r_sub;
	logic        ge;
	logic [31:0] num_hi;
	logic [32:0] mag;
	logic [32:0] sgn;

	// one restoring step
	assign r2    = {rem_q, quo_q[31]};
	assign r_sub = r2 - {1'b0, den_q};
	assign ge    = r2 >= {1'b0, den_q};

	// upper dividend bits; quotient of 2^32 or more is clamped at once
	assign num_hi = {{(64 - DIV_NUM_W){1'b0}}, req.num_mag[DIV_NUM_W-1:32]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_state_q <= DV_IDLE;
			cnt_q      <= '0;
		end else begin
			case (dv_state_q)
				DV_IDLE: begin
					if (req.start) begin
						cnt_q <= '0;
						if (num_hi >= req.den || req.num_mag == '0)
							dv_state_q <= DV_DONE;
						else
							dv_state_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1))
						dv_state_q <= DV_DONE;
				end
				DV_DONE: dv_state_q <= DV_IDLE;
				default: dv_state_q <= DV_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (dv_state_q == DV_IDLE && req.start) begin
			rem_q   <= num_hi;
			quo_q   <= req.num_mag[31:0];
			den_q   <= req.den;
			neg_q   <= req.neg;
			clamp_q <= num_hi >= req.den;
			zero_q  <= req.num_mag == '0;
		end else if (dv_state_q == DV_RUN) begin
			rem_q <= ge ? r_sub[31:0] : r2[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	// clamp magnitude at 2^31, apply sign, clip positive overflow
	always_comb begin
		if (zero_q)
			mag = '0;
		else if (clamp_q || quo_q > 32'h8000_0000)
			mag = 33'h0_8000_0000;
		else
			mag = {1'b0, quo_q};
		sgn = neg_q ? (33'd0 - mag) : mag;
		if (!neg_q && mag[31])
			rsp.quot = 32'sh7FFF_FFFF;
		else
			rsp.quot = sgn[31:0];
		rsp.done = dv_state_q == DV_DONE;
	end

endmodule

@@ sv/verlet_particle_integrator_unit.sv @@
// Position Verlet integrator for one 2D particle, signed Q16.16.
// in_ch carries an opcode word (place, add force, dampen, integrate) with a
// vector and a scalar; out_ch returns one word per input word: position,
// velocity and the divide error flag after that step. The cfg port writes
// mass, the immovable flag and the constant force; write it only when idle.
// One word is in flight at a time; in_ch.ready is high only while idle, but a
// finished word sits in the output register, so the next input is taken
// while the receiver has not yet picked up the last result.
// Integrate makes two passes through the single 32-step radix-2 divider for the
// accelerations and two for the velocities; with zero elapsed time the velocity
// passes are skipped. A division whose quotient clamps or whose dividend is zero
// goes straight to done without running the divider steps. For an immovable
// particle every opcode except add force goes straight to the done state. The
// next word is taken the cycle after a result loads.
// All products go through one 33x33 multiplier.
// Reset clears the particle state and loads mass 1.0, no constant force.
// When out_ch stalls, a finished word waits in its last state until the
// output register frees; nothing is dropped.
module verlet_particle_integrator_unit (
	input  logic              clk,
	input  logic              arst_n,
	vpi_in_if.sink            in_ch,
	vpi_out_if.source         out_ch,
	input  logic              cfg_we,
	input  vpi_pkg::cfg_idx_t cfg_index,
	input  logic [31:0]       cfg_data
);
	import vpi_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_FMX  = 5'd1;
	localparam logic [4:0] ST_FMY  = 5'd2;
	localparam logic [4:0] ST_FAY  = 5'd3;
	localparam logic [4:0] ST_DMX  = 5'd4;
	localparam logic [4:0] ST_DMY  = 5'd5;
	localparam logic [4:0] ST_DAY  = 5'd6;
	localparam logic [4:0] ST_ESQ  = 5'd7;
	localparam logic [4:0] ST_AXW  = 5'd8;
	localparam logic [4:0] ST_AYS  = 5'd9;
	localparam logic [4:0] ST_AYW  = 5'd10;
	localparam logic [4:0] ST_PX   = 5'd11;
	localparam logic [4:0] ST_PY   = 5'd12;
	localparam logic [4:0] ST_PYW  = 5'd13;
	localparam logic [4:0] ST_VXS  = 5'd14;
	localparam logic [4:0] ST_VXW  = 5'd15;
	localparam logic [4:0] ST_VYS  = 5'd16;
	localparam logic [4:0] ST_VYW  = 5'd17;
	localparam logic [4:0] ST_DONE = 5'd18;

	// configuration
	logic [31:0]        mass_q;
	logic               mass_inf_q;
	logic signed [31:0] cforce_x_q;
	logic signed [31:0] cforce_y_q;

	// particle state
	logic signed [31:0] pos_x_q, pos_y_q, prev_x_q, prev_y_q;
	logic signed [31:0] vel_x_q, vel_y_q, acc_x_q, acc_y_q;

	// sequencer and working registers
	logic [4:0]         state_q;
	logic [1:0]         op_q;
	logic signed [31:0] vx_q, vy_q;
	logic [31:0]        sc_q;
	logic [31:0]        esq_q;
	logic signed [31:0] accel_x_q, accel_y_q;
	logic               err_q;
	logic signed [65:0] prod_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] out_px_q, out_py_q, out_vx_q, out_vy_q;
	logic               out_err_q;

	logic               in_fire;
	logic               out_load;
	logic               mul_en;
	logic signed [32:0] mul_a, mul_b;
	logic signed [32:0] damp_t;
	logic signed [49:0] prod_sh;
	logic [31:0]        esq_d;
	logic signed [32:0] div_val;
	logic [32:0]        div_mag;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign in_ch.ready = state_q == ST_IDLE;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_load    = state_q == ST_DONE && (!out_valid_q || out_ch.ready);

	assign damp_t  = $signed({1'b0, Q_ONE}) - $signed({1'b0, sc_q});
	assign prod_sh = prod_q[65:16];
	assign esq_d   = (prod_q[65:48] != '0) ? 32'hFFFF_FFFF : prod_q[47:16];

	// shared multiplier operand select
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_FMX: begin
				mul_a = {vx_q[31], vx_q};
				mul_b = {1'b0, mass_q};
			end
			ST_FMY: begin
				mul_a = {vy_q[31], vy_q};
				mul_b = {1'b0, mass_q};
			end
			ST_DMX: begin
				mul_a = {pos_x_q[31], pos_x_q} - {prev_x_q[31], prev_x_q};
				mul_b = damp_t;
			end
			ST_DMY: begin
				mul_a = {pos_y_q[31], pos_y_q} - {prev_y_q[31], prev_y_q};
				mul_b = damp_t;
			end
			ST_ESQ: begin
				mul_a = {1'b0, sc_q};
				mul_b = {1'b0, sc_q};
			end
			ST_PX: begin
				mul_a = {accel_x_q[31], accel_x_q};
				mul_b = {1'b0, esq_q};
			end
			ST_PY: begin
				mul_a = {accel_y_q[31], accel_y_q};
				mul_b = {1'b0, esq_q};
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= mul_a * mul_b;
	end

	// divider request: acceleration = force / mass, velocity = delta / elapsed
	always_comb begin
		div_req.start = 1'b0;
		div_req.den   = sc_q;
		div_val       = {pos_x_q[31], pos_x_q} - {prev_x_q[31], prev_x_q};
		case (state_q)
			ST_ESQ: begin
				div_req.start = 1'b1;
				div_req.den   = mass_q;
				div_val       = {acc_x_q[31], acc_x_q};
			end
			ST_AYS: begin
				div_req.start = 1'b1;
				div_req.den   = mass_q;
				div_val       = {acc_y_q[31], acc_y_q};
			end
			ST_VXS: div_req.start = 1'b1;
			ST_VYS: begin
				div_req.start = 1'b1;
				div_val       = {pos_y_q[31], pos_y_q} - {prev_y_q[31], prev_y_q};
			end
			default: div_req.start = 1'b0;
		endcase
		div_mag         = div_val[32] ? (33'd0 - div_val) : div_val;
		div_req.neg     = div_val[32];
		div_req.num_mag = {1'b0, div_mag, 16'h0000};
	end

	vpi_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q     <= Q_ONE;
			mass_inf_q <= 1'b0;
			cforce_x_q <= '0;
			cforce_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MASS:     mass_q     <= cfg_data;
				CFG_MASS_INF: mass_inf_q <= cfg_data[0];
				CFG_CFORCE_X: cforce_x_q <= cfg_data;
				CFG_CFORCE_Y: cforce_y_q <= cfg_data;
				default:      mass_q     <= mass_q;
			endcase
		end
	end

	// latched input word
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q <= in_ch.opcode;
			vx_q <= in_ch.vector_x;
			vy_q <= in_ch.vector_y;
			sc_q <= in_ch.scalar_value;
		end
	end

	// sequencer and particle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			vel_x_q   <= '0;
			vel_y_q   <= '0;
			acc_x_q   <= '0;
			acc_y_q   <= '0;
			err_q     <= 1'b0;
			esq_q     <= '0;
			accel_x_q <= '0;
			accel_y_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						err_q <= 1'b0;
						case (in_ch.opcode)
							OP_PLACE: begin
								pos_x_q  <= in_ch.vector_x;
								pos_y_q  <= in_ch.vector_y;
								prev_x_q <= in_ch.vector_x;
								prev_y_q <= in_ch.vector_y;
								vel_x_q  <= '0;
								vel_y_q  <= '0;
								acc_x_q  <= '0;
								acc_y_q  <= '0;
								state_q  <= ST_DONE;
							end
							OP_FORCE: state_q <= ST_FMX;
							OP_DAMP:  state_q <= mass_inf_q ? ST_DONE : ST_DMX;
							default: begin
								if (mass_inf_q) begin
									acc_x_q <= cforce_x_q;
									acc_y_q <= cforce_y_q;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_ESQ;
								end
							end
						endcase
					end
				end
				// add force: acc += sat(v * mass)
				ST_FMX: state_q <= ST_FMY;
				ST_FMY: begin
					acc_x_q <= sat32(sx32(acc_x_q) + sx32(sat32(sx50(prod_sh))));
					state_q <= ST_FAY;
				end
				ST_FAY: begin
					acc_y_q <= sat32(sx32(acc_y_q) + sx32(sat32(sx50(prod_sh))));
					state_q <= ST_DONE;
				end
				// dampen: prev += (pos - prev) * (1 - damp)
				ST_DMX: state_q <= ST_DMY;
				ST_DMY: begin
					prev_x_q <= sat32(sx32(prev_x_q) + sx50(prod_sh));
					state_q  <= ST_DAY;
				end
				ST_DAY: begin
					prev_y_q <= sat32(sx32(prev_y_q) + sx50(prod_sh));
					state_q  <= ST_DONE;
				end
				// integrate: elapsed squared and x acceleration in parallel
				ST_ESQ: state_q <= ST_AXW;
				ST_AXW: begin
					esq_q <= esq_d;
					if (div_rsp.done) begin
						accel_x_q <= div_rsp.quot;
						state_q   <= ST_AYS;
					end
				end
				ST_AYS: state_q <= ST_AYW;
				ST_AYW: begin
					if (div_rsp.done) begin
						accel_y_q <= div_rsp.quot;
						state_q   <= ST_PX;
					end
				end
				ST_PX: state_q <= ST_PY;
				ST_PY: begin
					pos_x_q  <= sat32(sx32(pos_x_q) + sx32(pos_x_q) - sx32(prev_x_q)
						+ sx50(prod_sh));
					prev_x_q <= pos_x_q;
					state_q  <= ST_PYW;
				end
				ST_PYW: begin
					pos_y_q  <= sat32(sx32(pos_y_q) + sx32(pos_y_q) - sx32(prev_y_q)
						+ sx50(prod_sh));
					prev_y_q <= pos_y_q;
					if (sc_q == '0) begin
						err_q   <= 1'b1;
						acc_x_q <= cforce_x_q;
						acc_y_q <= cforce_y_q;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_VXS;
					end
				end
				// velocity from the position step
				ST_VXS: state_q <= ST_VXW;
				ST_VXW: begin
					if (div_rsp.done) begin
						vel_x_q <= div_rsp.quot;
						state_q <= ST_VYS;
					end
				end
				ST_VYS: state_q <= ST_VYW;
				ST_VYW: begin
					if (div_rsp.done) begin
						vel_y_q <= div_rsp.quot;
						acc_x_q <= cforce_x_q;
						acc_y_q <= cforce_y_q;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_px_q  <= pos_x_q;
			out_py_q  <= pos_y_q;
			out_vx_q  <= vel_x_q;
			out_vy_q  <= vel_y_q;
			out_err_q <= err_q;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.position_x_out = out_px_q;
	assign out_ch.position_y_out = out_py_q;
	assign out_ch.velocity_x_out = out_vx_q;
	assign out_ch.velocity_y_out = out_vy_q;
	assign out_ch.divide_error   = out_err_q;

	// divider answers only while the sequencer waits on it
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_AXW || state_q == ST_AYW
			|| state_q == ST_VXW || state_q == ST_VYW))
		else $error("divider done outside a wait state");

	// error flag only from integrate on a movable particle
	a_err_integ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && err_q) |-> (op_q == OP_INTEG && !mass_inf_q && sc_q == '0))
		else $error("divide error on a step that cannot divide");

	// an accepted word always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != ST_IDLE)
		else $error("accepted word did not start");

	// a finished word waits while the output register is full and stalled
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !out_ch.ready) |=> state_q == ST_DONE)
		else $error("result lost under output stall");

endmodule
